// ===== rtl/gic_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gic_pkg: shared types and constants of the gamepad input conditioner
// Transaction payloads, channel kind codes, register indexes and divider sizes.
// ----------------------------------------------------------------------------
package gic_pkg;

    // Channel kind codes, used for both input op and output kind
    localparam logic [1:0] OP_AXIS   = 2'd0;
    localparam logic [1:0] OP_BUTTON = 2'd1;
    localparam logic [1:0] OP_HAT    = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS0        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS1        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS2        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS3        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_EN    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_DELAY = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CALIB        = 3'd6;

    localparam int CFG_DATA_W = 64;
    localparam logic [CFG_DATA_W-1:0] AXIS_SETUP_RST = 64'h0000_0000_7FFF_8000;

    // Scaled axis divider: 31-bit magnitude numerator, 16-bit divisor,
    // 15 quotient bits (larger quotients saturate before the divide)
    localparam int NUM_W  = 31;
    localparam int DEN_W  = 16;
    localparam int QUO_W  = 15;
    localparam int DCNT_W = $clog2(QUO_W + 1);

    typedef struct packed {
        logic [1:0]         op;
        logic [3:0]         channel;
        logic signed [15:0] reading;
        logic [31:0]        now_ms;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         kind;
        logic [3:0]         which;
        logic signed [15:0] level;
    } t_out_item;

endpackage

// ===== rtl/gic_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gic_div: iterative restoring divider for axis scaling
// One compare and subtract per cycle, one quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module gic_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [gic_pkg::NUM_W-1:0] i_num,
    input  logic [gic_pkg::DEN_W-1:0] i_den,
    output logic                      o_done,
    output logic [gic_pkg::QUO_W-1:0] o_quo
);
    import gic_pkg::*;

    logic [NUM_W-1:0]  r_rem;
    logic [NUM_W-1:0]  r_dvs;
    logic [QUO_W-1:0]  r_quo;
    logic [DCNT_W-1:0] r_cnt;
    logic              r_done;
    logic              w_fit;

    assign w_fit = (r_rem >= r_dvs);

    // Control: step counter and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= DCNT_W'(QUO_W);
            r_done <= 1'b0;
        end else if (r_cnt != '0) begin
            r_cnt  <= r_cnt - 1'b1;
            r_done <= (r_cnt == DCNT_W'(1));
        end else begin
            r_done <= 1'b0;
        end
    end

    // Datapath: shift the divisor down, subtract where it fits
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num;
            r_dvs <= NUM_W'({i_den, (QUO_W - 1)'(0)});
            r_quo <= '0;
        end else if (r_cnt != '0) begin
            if (w_fit) begin
                r_rem <= r_rem - r_dvs;
            end
            r_dvs <= r_dvs >> 1;
            r_quo <= {r_quo[QUO_W-2:0], w_fit};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// ===== rtl/gamepad_input_conditioner.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gamepad_input_conditioner: axis, button and hat conditioning
// Sequence: buttons, hats and calibrating axes go from accept through track
//   and emit to the output register; a scaled axis first passes centre, scale,
//   range check and a 15-step shared divider. Flat axes skip scale, check and
//   divide; saturating axes skip the divide. One transaction at a time: input
//   stall is high until the result is in the output register or the item gives
//   no report, and stays high while a report waits on a stalled output register.
// Reset: synchronous active low; clears all channel history, setup registers
//   to full range with no deadzone, auto-repeat off, not calibrating.
// ----------------------------------------------------------------------------
module gamepad_input_conditioner #(
    parameter int NUM_AXES    = 4,
    parameter int NUM_BUTTONS = 16,
    parameter int NUM_HATS    = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [gic_pkg::CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [gic_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  gic_pkg::t_in_item              i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output gic_pkg::t_out_item             o_out_data
);
    import gic_pkg::*;

    localparam int AIW = (NUM_AXES > 1)    ? $clog2(NUM_AXES)    : 1;
    localparam int BIW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
    localparam int HIW = (NUM_HATS > 1)    ? $clog2(NUM_HATS)    : 1;
    localparam logic [4:0] AXES_LIM = 5'(NUM_AXES);
    localparam logic [4:0] BTNS_LIM = 5'(NUM_BUTTONS);
    localparam logic [4:0] HATS_LIM = 5'(NUM_HATS);

    // Sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CTR   = 3'd1;
    localparam logic [2:0] S_SCALE = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_TRACK = 3'd5;
    localparam logic [2:0] S_EMIT  = 3'd6;

    // Configuration
    logic [CFG_DATA_W-1:0] r_setup [0:3];
    logic                  r_rep_en;
    logic [15:0]           r_delay;
    logic                  r_calib;

    // Channel history
    logic signed [15:0] r_axis_last  [0:NUM_AXES-1];
    logic [31:0]        r_axis_since [0:NUM_AXES-1];
    logic               r_btn_last   [0:NUM_BUTTONS-1];
    logic [31:0]        r_btn_since  [0:NUM_BUTTONS-1];
    logic [3:0]         r_hat_last   [0:NUM_HATS-1];
    logic [31:0]        r_hat_since  [0:NUM_HATS-1];

    // Sequencer and working registers
    logic [2:0]         r_state;
    logic [1:0]         r_kind;
    logic [3:0]         r_ch;
    logic signed [15:0] r_raw;
    logic [31:0]        r_now;
    logic signed [15:0] r_val;
    logic signed [15:0] r_ctr;
    logic [DEN_W-1:0]   r_den;
    logic [NUM_W-1:0]   r_num;
    logic               r_neg;
    logic               r_rep;
    logic signed [15:0] r_level;
    logic               r_out_valid;
    t_out_item          r_out;

    // Combinational terms
    logic                  w_accept;
    logic                  w_in_range;
    logic [CFG_DATA_W-1:0] w_setup;
    logic signed [16:0]    w_mn;
    logic signed [16:0]    w_mx;
    logic signed [16:0]    w_sum;
    logic signed [16:0]    w_half;
    logic signed [16:0]    w_span;
    logic [16:0]           w_cmag;
    logic [32:0]           w_scaled;
    logic                  w_ovf;
    logic                  w_div_start;
    logic                  w_div_done;
    logic [QUO_W-1:0]      w_quo;
    logic [15:0]           w_qext;
    logic [AIW-1:0]        w_aidx;
    logic [BIW-1:0]        w_bidx;
    logic [HIW-1:0]        w_hidx;
    logic signed [15:0]    w_last;
    logic [31:0]           w_since;
    logic [15:0]           w_dz;
    logic [15:0]           w_sens;
    logic [16:0]           w_vmag;
    logic signed [16:0]    w_diff;
    logic [16:0]           w_dmag;
    logic [31:0]           w_elapsed;
    logic                  w_rep;
    logic signed [15:0]    w_level;
    logic                  w_upd_last;
    logic                  w_upd_since;
    logic                  w_slot_free;

    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign w_slot_free = !r_out_valid || !i_out_stall;

    // Check channel index against the count for its kind
    always_comb begin
        case (i_in_data.op)
            OP_AXIS:   w_in_range = ({1'b0, i_in_data.channel} < AXES_LIM);
            OP_BUTTON: w_in_range = ({1'b0, i_in_data.channel} < BTNS_LIM);
            OP_HAT:    w_in_range = ({1'b0, i_in_data.channel} < HATS_LIM);
            default:   w_in_range = 1'b0;
        endcase
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_setup[i] <= AXIS_SETUP_RST;
            end
            r_rep_en <= 1'b0;
            r_delay  <= '0;
            r_calib  <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_AXIS0:        r_setup[0] <= i_cfg_wdata;
                REG_AXIS1:        r_setup[1] <= i_cfg_wdata;
                REG_AXIS2:        r_setup[2] <= i_cfg_wdata;
                REG_AXIS3:        r_setup[3] <= i_cfg_wdata;
                REG_REPEAT_EN:    r_rep_en   <= i_cfg_wdata[0];
                REG_REPEAT_DELAY: r_delay    <= i_cfg_wdata[15:0];
                REG_CALIB:        r_calib    <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    // Centre: c = (max + min) / 2 toward zero, span = max - min
    assign w_setup = r_setup[r_ch[1:0]];
    assign w_mn    = {w_setup[15], w_setup[15:0]};
    assign w_mx    = {w_setup[31], w_setup[31:16]};
    assign w_sum   = w_mx + w_mn;
    assign w_half  = (w_sum + {16'd0, w_sum[16]}) >>> 1;
    assign w_span  = w_mx - w_mn;

    // Scale: |r| * 65535 as a shift and subtract
    assign w_cmag   = r_ctr[15] ? (17'd0 - {r_ctr[15], r_ctr}) : {1'b0, r_ctr};
    assign w_scaled = {w_cmag, 16'd0} - {16'd0, w_cmag};

    // Quotient of 2^15 or more saturates
    assign w_ovf       = (r_num >= NUM_W'({r_den, 15'd0}));
    assign w_div_start = (r_state == S_CHECK) && !w_ovf;
    assign w_qext      = {1'b0, w_quo};

    gic_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    // Select history of the current channel
    assign w_aidx = r_ch[AIW-1:0];
    assign w_bidx = r_ch[BIW-1:0];
    assign w_hidx = r_ch[HIW-1:0];

    always_comb begin
        case (r_kind)
            OP_AXIS: begin
                w_last  = r_axis_last[w_aidx];
                w_since = r_axis_since[w_aidx];
                w_dz    = w_setup[47:32];
                w_sens  = w_setup[63:48];
            end
            OP_BUTTON: begin
                w_last  = {15'd0, r_btn_last[w_bidx]};
                w_since = r_btn_since[w_bidx];
                w_dz    = '0;
                w_sens  = '0;
            end
            OP_HAT: begin
                w_last  = {12'd0, r_hat_last[w_hidx]};
                w_since = r_hat_since[w_hidx];
                w_dz    = '0;
                w_sens  = '0;
            end
            default: begin
                w_last  = '0;
                w_since = '0;
                w_dz    = '0;
                w_sens  = '0;
            end
        endcase
    end

    // Deadzone, change and repeat decision
    assign w_vmag    = r_val[15] ? (17'd0 - {r_val[15], r_val}) : {1'b0, r_val};
    assign w_diff    = {w_last[15], w_last} - {r_val[15], r_val};
    assign w_dmag    = w_diff[16] ? (17'd0 - w_diff) : w_diff;
    assign w_elapsed = r_now - w_since;

    always_comb begin
        w_level     = r_val;
        w_upd_last  = 1'b0;
        w_upd_since = 1'b0;
        if (w_vmag < {1'b0, w_dz}) begin
            w_rep   = 1'b1;
            w_level = '0;
        end else if (r_val != w_last) begin
            w_upd_last  = 1'b1;
            w_upd_since = 1'b1;
            w_rep       = (w_dmag >= {1'b0, w_sens});
        end else if (r_rep_en && (r_val != '0)) begin
            w_rep = (w_elapsed >= {16'd0, r_delay});
        end else begin
            w_upd_since = 1'b1;
            w_rep       = 1'b0;
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept && w_in_range) begin
                        if (i_in_data.op == OP_AXIS && !r_calib) begin
                            r_state <= S_CTR;
                        end else begin
                            r_state <= S_TRACK;
                        end
                    end
                end
                S_CTR: begin
                    if (w_span <= 17'sd0) begin
                        r_state <= S_TRACK;
                    end else begin
                        r_state <= S_SCALE;
                    end
                end
                S_SCALE: r_state <= S_CHECK;
                S_CHECK: begin
                    if (w_ovf) begin
                        r_state <= S_TRACK;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_state <= S_TRACK;
                    end
                end
                S_TRACK: r_state <= S_EMIT;
                S_EMIT: begin
                    if (!r_rep || w_slot_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Working datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_kind <= i_in_data.op;
                r_ch   <= i_in_data.channel;
                r_raw  <= i_in_data.reading;
                r_now  <= i_in_data.now_ms;
                case (i_in_data.op)
                    OP_BUTTON: r_val <= {15'd0, (i_in_data.reading != '0)};
                    OP_HAT:    r_val <= {12'd0, i_in_data.reading[3:0]};
                    default:   r_val <= i_in_data.reading;
                endcase
            end
            S_CTR: begin
                r_ctr <= r_raw - w_half[15:0];
                r_den <= w_span[15:0];
                r_val <= '0;
            end
            S_SCALE: begin
                r_num <= w_scaled[NUM_W-1:0];
                r_neg <= r_ctr[15];
            end
            S_CHECK: begin
                r_val <= r_neg ? 16'sh8000 : 16'sh7FFF;
            end
            S_DIV: begin
                r_val <= r_neg ? (16'd0 - w_qext) : w_qext;
            end
            S_TRACK: begin
                r_rep   <= w_rep;
                r_level <= w_level;
            end
            default: begin
            end
        endcase
    end

    // Channel history update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                r_axis_last[i]  <= '0;
                r_axis_since[i] <= '0;
            end
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                r_btn_last[i]  <= 1'b0;
                r_btn_since[i] <= '0;
            end
            for (int i = 0; i < NUM_HATS; i++) begin
                r_hat_last[i]  <= '0;
                r_hat_since[i] <= '0;
            end
        end else if (r_state == S_TRACK) begin
            case (r_kind)
                OP_AXIS: begin
                    if (w_upd_last)  r_axis_last[w_aidx]  <= r_val;
                    if (w_upd_since) r_axis_since[w_aidx] <= r_now;
                end
                OP_BUTTON: begin
                    if (w_upd_last)  r_btn_last[w_bidx]  <= r_val[0];
                    if (w_upd_since) r_btn_since[w_bidx] <= r_now;
                end
                OP_HAT: begin
                    if (w_upd_last)  r_hat_last[w_hidx]  <= r_val[3:0];
                    if (w_upd_since) r_hat_since[w_hidx] <= r_now;
                end
                default: begin
                end
            endcase
        end
    end

    // Output register: load a report, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_EMIT && r_rep && w_slot_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EMIT && r_rep && w_slot_free) begin
            r_out.kind  <= r_kind;
            r_out.which <= r_ch;
            r_out.level <= r_level;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Divider finishes only while the sequencer waits for it
    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV))
        else $error("divider done outside divide state");

    // A new transaction appears only out of the emit state
    a_out_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !$past(o_out_valid)) |-> ($past(r_state) == S_EMIT))
        else $error("output loaded outside emit state");

    // Unknown kinds are dropped without leaving idle
    a_drop_unknown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in_data.op == OP_NONE) |=> (r_state == S_IDLE))
        else $error("unknown channel kind was not dropped");

    // Button values are 0 or 1 when tracked
    a_button_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TRACK && r_kind == OP_BUTTON) |-> (r_val[15:1] == '0))
        else $error("button value wider than one bit");

endmodule
